[rtl/d2d_pkg.sv]
// d2d_pkg: widths, codes and the divider stage payload shared by the
// depth-to-disparity pipeline files. No dependencies.
`timescale 1ns / 1ps

package d2d_pkg;

    localparam int DEPTH_W    = 16;
    localparam int GAIN_W     = 16;
    localparam int OFFS_W     = 13;
    localparam int DIFF_W     = DEPTH_W + 1;        // depth - zero_plane
    localparam int DEN_W      = DEPTH_W + 2;        // diff + view_distance
    localparam int PROD_A_W   = GAIN_W + DIFF_W;
    localparam int PROD_B_W   = OFFS_W + DEN_W;
    localparam int NUM_W      = PROD_A_W + 1;
    localparam int DIVD_W     = DEN_W - 1;          // den once known positive
    localparam int QUO_W      = 8;
    localparam int Q_SHIFT    = QUO_W + 4;          // 256 * 16
    localparam int REM_W      = DIVD_W + Q_SHIFT;
    localparam int DSR_SHIFT  = REM_W - 1 - DIVD_W;
    localparam int STEPS      = 2;                  // quotient bits per stage
    localparam int DIV_STAGES = QUO_W / STEPS;
    localparam int PRE_STAGES = 4;
    localparam int NSTAGES    = PRE_STAGES + DIV_STAGES;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [DEPTH_W-1:0]       ZERO_PLANE_RST = 16'd1883;
    localparam logic [DEPTH_W-1:0]       VIEW_DIST_RST  = 16'd25316;
    localparam logic signed [GAIN_W-1:0] GAIN_RST       = -16'sd25381;
    localparam logic signed [OFFS_W-1:0] OFFS_RST       = 13'sd2040;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_LOW     = 2'd1,
        ST_HIGH    = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ZERO_PLANE = 2'd0,
        REG_VIEW_DIST  = 2'd1,
        REG_GAIN       = 2'd2,
        REG_OFFSET     = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [DIVD_W-1:0] den;
        logic [QUO_W-1:0]  quo;
        status_t           code;
    } d2d_div_t;

endpackage

[rtl/depth_to_disparity_top.sv]
// depth_to_disparity_top: depth sample to saturated disparity byte, eight
// register stages. Depends on d2d_pkg and d2d_div_stage.
`timescale 1ns / 1ps
//
//  channel   signals                           width        dir
//  in        in_valid in_ready depth            16           in
//  out       out_valid out_ready disparity      8, status 2  out
//  cfg       cfg_we cfg_index cfg_data          2, 16        in
//
//  One pixel per cycle while not stalled; stages: difference/denominator, two
//  multipliers, sum, range check, then four divider stages of two bits each.
//  Stall: the whole pipeline holds while the output is valid and not taken.
//  Reset clears the stage valid bits and loads the register defaults.

module depth_to_disparity_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [d2d_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [d2d_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [d2d_pkg::DEPTH_W-1:0]         depth,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [d2d_pkg::QUO_W-1:0]           disparity,
    output logic [1:0]                          status
);
    import d2d_pkg::*;

    logic [DEPTH_W-1:0]        zero_plane_reg;
    logic [DEPTH_W-1:0]        view_dist_reg;
    logic signed [GAIN_W-1:0]  gain_reg;
    logic signed [OFFS_W-1:0]  offset_reg;

    logic [NSTAGES-1:0]        v_reg;
    logic                      advance;

    logic signed [DIFF_W-1:0]   s1_diff_next, s1_diff_reg;
    logic signed [DEN_W-1:0]    s1_den_next, s1_den_reg;
    logic signed [PROD_A_W-1:0] s2_prod_a_next, s2_prod_a_reg;
    logic signed [PROD_B_W-1:0] s2_prod_b_next, s2_prod_b_reg;
    logic [DIVD_W-1:0]          s2_den_reg, s3_den_reg;
    logic                       s2_invalid_reg, s3_invalid_reg;
    logic signed [NUM_W-1:0]    s3_num_next, s3_num_reg;
    logic signed [NUM_W-1:0]    s3_limit;
    d2d_div_t                   s4_next, s4_reg;
    d2d_div_t                   div_q [0:DIV_STAGES];
    d2d_div_t                   last;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_plane_reg <= ZERO_PLANE_RST;
            view_dist_reg  <= VIEW_DIST_RST;
            gain_reg       <= GAIN_RST;
            offset_reg     <= OFFS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ZERO_PLANE: zero_plane_reg <= cfg_data[DEPTH_W-1:0];
                REG_VIEW_DIST:  view_dist_reg  <= cfg_data[DEPTH_W-1:0];
                REG_GAIN:       gain_reg       <= $signed(cfg_data[GAIN_W-1:0]);
                REG_OFFSET:     offset_reg     <= $signed(cfg_data[OFFS_W-1:0]);
                default:        ;
            endcase
        end
    end

    // global stall: everything moves when the output slot frees up
    assign advance  = !v_reg[NSTAGES-1] || out_ready;
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (advance)
        begin
            v_reg <= {v_reg[NSTAGES-2:0], in_valid};
        end
    end

    // stage 1: difference and denominator
    assign s1_diff_next = $signed({1'b0, depth}) - $signed({1'b0, zero_plane_reg});
    assign s1_den_next  = $signed({s1_diff_next[DIFF_W-1], s1_diff_next})
                        + $signed({2'b00, view_dist_reg});

    // stage 2: gain*diff and offset*den
    assign s2_prod_a_next = PROD_A_W'(gain_reg) * PROD_A_W'(s1_diff_reg);
    assign s2_prod_b_next = PROD_B_W'(offset_reg) * PROD_B_W'(s1_den_reg);

    // stage 3: numerator
    assign s3_num_next = NUM_W'(s2_prod_a_reg) + NUM_W'(s2_prod_b_reg);

    // stage 4: classify; only in-range values go through the divider
    assign s3_limit = $signed({{(NUM_W-DIVD_W-Q_SHIFT){1'b0}}, s3_den_reg,
                               {Q_SHIFT{1'b0}}});

    always_comb
    begin
        s4_next.den  = s3_den_reg;
        s4_next.quo  = '0;
        s4_next.rem  = '0;
        if (s3_invalid_reg)
        begin
            s4_next.code = ST_INVALID;
        end
        else if (s3_num_reg[NUM_W-1])
        begin
            s4_next.code = ST_LOW;
        end
        else if (s3_num_reg >= s3_limit)
        begin
            s4_next.code = ST_HIGH;
        end
        else
        begin
            s4_next.code = ST_OK;
            s4_next.rem  = s3_num_reg[REM_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_diff_reg    <= s1_diff_next;
            s1_den_reg     <= s1_den_next;
            s2_prod_a_reg  <= s2_prod_a_next;
            s2_prod_b_reg  <= s2_prod_b_next;
            s2_den_reg     <= s1_den_reg[DIVD_W-1:0];
            s2_invalid_reg <= s1_den_reg[DEN_W-1] || (s1_den_reg == '0);
            s3_num_reg     <= s3_num_next;
            s3_den_reg     <= s2_den_reg;
            s3_invalid_reg <= s2_invalid_reg;
            s4_reg         <= s4_next;
        end
    end

    assign div_q[0] = s4_reg;

    // stages 5..8: divider
    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        d2d_div_stage u_stage (
            .clk      (clk),
            .en       (advance),
            .din      (div_q[g]),
            .dout_reg (div_q[g+1])
        );
    end

    assign last      = div_q[DIV_STAGES];
    assign out_valid = v_reg[NSTAGES-1];
    assign status    = last.code;

    always_comb
    begin
        case (last.code)
            ST_OK:   disparity = last.quo;
            ST_HIGH: disparity = '1;
            default: disparity = '0;
        endcase
    end

    // range check must leave the divider an 8-bit quotient
    a_div_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[PRE_STAGES-1] && div_q[0].code == ST_OK
        |-> div_q[0].rem < {1'b0, div_q[0].den, {DSR_SHIFT{1'b0}}, 1'b0})
        else $error("divider input out of range");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last.code == ST_OK
        |-> last.rem < {1'b0, last.den, {DSR_SHIFT{1'b0}}, 1'b0})
        else $error("divider remainder out of range");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> v_reg[0])
        else $error("accepted transfer lost at entry");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(v_reg) && $stable(last))
        else $error("pipeline moved during stall");

endmodule

[rtl/d2d_div_stage.sv]
// d2d_div_stage: one register stage of the restoring divider, two quotient
// bits per stage. Depends on d2d_pkg.
`timescale 1ns / 1ps

module d2d_div_stage (
    input  logic              clk,
    input  logic              en,
    input  d2d_pkg::d2d_div_t din,
    output d2d_pkg::d2d_div_t dout_reg
);
    import d2d_pkg::*;

    d2d_div_t                 dout_next;
    logic [REM_W-1:0]         dsr;
    logic [REM_W-1:0]         rem;
    logic [QUO_W-1:0]         quo;

    // divisor is fixed at 16*den*128; the remainder shifts left instead
    assign dsr = {1'b0, din.den, {DSR_SHIFT{1'b0}}};

    always_comb
    begin
        rem = din.rem;
        quo = din.quo;
        for (int i = 0; i < STEPS; i++)
        begin
            if (rem >= dsr)
            begin
                rem = rem - dsr;
                quo = {quo[QUO_W-2:0], 1'b1};
            end
            else
            begin
                quo = {quo[QUO_W-2:0], 1'b0};
            end
            rem = {rem[REM_W-2:0], 1'b0};
        end
        dout_next      = din;
        dout_next.rem  = rem;
        dout_next.quo  = quo;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

endmodule
